### rtl/pfsbp_pkg.sv
package pfsbp_pkg;

    // Field and group geometry.
    localparam int DATA_BITS   = 7;
    localparam int BYTE_BITS   = 8;
    localparam int GROUP_BYTES = 8;
    localparam int OUT_BYTES   = 7;
    localparam int GROUP_W     = DATA_BITS * (GROUP_BYTES - 1);
    localparam int PACK_W      = BYTE_BITS * OUT_BYTES;
    localparam int COUNT_W     = $clog2(GROUP_BYTES);
    localparam int REMAIN_W    = $clog2(OUT_BYTES + 1);

    typedef logic [BYTE_BITS-1:0] byte_t;
    typedef logic [DATA_BITS-1:0] data_t;
    typedef logic [GROUP_W-1:0]   group_t;
    typedef logic [PACK_W-1:0]    pack_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [REMAIN_W-1:0]  remain_t;

    localparam count_t  LAST_COUNT = count_t'(GROUP_BYTES - 1);
    localparam remain_t FULL_LOAD  = remain_t'(OUT_BYTES);
    localparam remain_t ONE_LEFT   = remain_t'(1);
    localparam remain_t EMPTY      = remain_t'(0);

    // Parity over all bits of a byte: 1 means an odd number of ones.
    function automatic logic odd_parity(input byte_t b);
        return ^b;
    endfunction

endpackage

### rtl/parity_filter_seven_bit_packer.sv
// Even-parity filter and seven-bit packer. Each input transaction carries one raw byte;
// a byte with an odd number of one bits is dropped, and a byte with even parity
// contributes bits 7..1. Every eighth kept byte completes a group of 56 bits, which
// leaves as seven output transactions, most significant byte first, with last_of_group
// set on the seventh. A partial group is held and never emitted. An input byte is
// taken every cycle; the only input stall comes from the seven-byte output holding
// register, which drains one byte per cycle while out_stall is low: any byte that
// arrives while seven bytes are already held waits, whatever its parity, while the
// previous group still has more than one byte left to send (or one byte that is
// stalled). With no output stall the block sustains one input byte per cycle.
module parity_filter_seven_bit_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pfsbp_pkg::byte_t  in_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output pfsbp_pkg::byte_t  out_byte,
    output logic              last_of_group
);
    import pfsbp_pkg::*;

    group_t  group_reg,  group_next;
    count_t  count_reg,  count_next;
    pack_t   pack_reg,   pack_next;
    remain_t remain_reg, remain_next;

    logic  in_fire;
    logic  out_fire;
    logic  keep;
    logic  load;
    data_t data;

    // Handshake decode.
    assign out_valid = (remain_reg != EMPTY);
    assign out_fire  = out_valid && !out_stall;
    assign in_stall  = (count_reg == LAST_COUNT) && (remain_reg != EMPTY)
                       && !((remain_reg == ONE_LEFT) && !out_stall);
    assign in_fire   = in_valid && !in_stall;

    assign data = in_byte[BYTE_BITS-1:1];
    assign keep = in_fire && !odd_parity(in_byte);
    assign load = keep && (count_reg == LAST_COUNT);

    // Collection store: shift in seven bits per kept byte, restart on a full group.
    always_comb
    begin
        group_next = group_reg;
        count_next = count_reg;
        if (load)
        begin
            group_next = '0;
            count_next = '0;
        end
        else if (keep)
        begin
            group_next = {group_reg[GROUP_W-DATA_BITS-1:0], data};
            count_next = count_reg + count_t'(1);
        end
    end

    // Output holding register: load a full group, then shift out one byte per transaction.
    always_comb
    begin
        pack_next   = pack_reg;
        remain_next = remain_reg;
        if (load)
        begin
            pack_next   = {group_reg, data};
            remain_next = FULL_LOAD;
        end
        else if (out_fire)
        begin
            pack_next   = {pack_reg[PACK_W-BYTE_BITS-1:0], byte_t'(0)};
            remain_next = remain_reg - remain_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg  <= '0;
            count_reg  <= '0;
            remain_reg <= EMPTY;
        end
        else
        begin
            group_reg  <= group_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pack_reg <= pack_next;
    end

    assign out_byte      = pack_reg[PACK_W-1:PACK_W-BYTE_BITS];
    assign last_of_group = (remain_reg == ONE_LEFT);

    // A group is loaded only when the holding register is empty or sends its last byte now.
    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((remain_reg == EMPTY) || ((remain_reg == ONE_LEFT) && out_fire)))
        else $error("group loaded over unsent output bytes");

    // A load always presents a full group of seven bytes next cycle.
    a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (remain_reg == FULL_LOAD))
        else $error("loaded group does not hold seven bytes");

    // The collection count moves only on an accepted input transaction.
    a_count_only_on_input: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(count_reg) && $stable(group_reg))
        else $error("collection store changed without an input transaction");

    // Sending the last byte of a group empties the holding register unless a new group loads.
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_of_group && !load) |=> !out_valid)
        else $error("output still valid after the last byte of a group");

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfsbp_pkg::*;

    // One packed output byte as the checker expects to see it.
    typedef struct packed {
        byte_t value;
        logic  last;
    } packed_byte_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    byte_t in_byte;
    logic  out_valid;
    logic  out_stall;
    byte_t out_byte;
    logic  last_of_group;

    // Packer state as predicted, and the bytes still owed by the block.
    group_t       held_bits;
    count_t       held_count;
    packed_byte_t pending_bytes[$];

    // Idle switches for each side of the block.
    bit in_idle_on;
    bit out_idle_on;

    int items_sent;
    int items_dropped;
    int groups_done;
    int bytes_checked;
    int failures;

    parity_filter_seven_bit_packer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_of_group (last_of_group)
    );

    // Free-running 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Number of idle cycles a side inserts before its next transaction.
    function automatic int draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, 11) : 0;
    endfunction

    // Random seven data bits with the parity bit chosen to make the byte even or odd.
    function automatic byte_t make_byte(input bit even);
        data_t d;
        d = data_t'($urandom_range(0, 127));
        return even ? {d, ^d} : {d, ~^d};
    endfunction

    // Reports one failure; only the first ten are printed.
    task automatic report_failure(input string what);
        failures++;
        if (failures <= 10)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Predicts the effect of one accepted byte on the packer and queues its output bytes.
    task automatic absorb_byte(input byte_t b);
        pack_t full;
        items_sent++;
        if (^b)
        begin
            items_dropped++;
            return;
        end
        if (held_count != LAST_COUNT)
        begin
            held_bits  = {held_bits[GROUP_W-DATA_BITS-1:0], b[BYTE_BITS-1:1]};
            held_count = held_count + count_t'(1);
            return;
        end
        full = {held_bits, b[BYTE_BITS-1:1]};
        for (int k = 0; k < OUT_BYTES; k++)
        begin
            pending_bytes.push_back('{value: full[PACK_W-1-BYTE_BITS*k -: BYTE_BITS],
                                      last:  (k == OUT_BYTES - 1)});
        end
        groups_done++;
        held_bits  = '0;
        held_count = '0;
    endtask

    // Sends one input transaction after a random gap and waits until it is taken.
    task automatic send_byte(input byte_t b);
        int gap;
        bit taken;
        gap = draw_wait(in_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            if (taken)
            begin
                absorb_byte(b);
            end
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Extremes and both parities: one full group built from edge values, odd bytes interleaved.
    task automatic test_parity_and_extremes();
        byte_t seq[12];
        seq = '{8'h00, 8'h01, 8'hFF, 8'hFE, 8'h80, 8'h03,
                8'h7F, 8'hC0, 8'hAA, 8'h55, 8'h81, 8'h7E};
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
    endtask

    // A group of all ones sent back to back with no idling on either side.
    task automatic test_all_ones_group();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (8) send_byte(8'hFF);
    endtask

    // Mostly even bytes so groups complete often, with odd bytes and noise mixed in.
    task automatic test_random_stream(input int even_items, input bit in_on, input bit out_on);
        int    kept;
        int    pick;
        byte_t b;
        kept        = 0;
        in_idle_on  = in_on;
        out_idle_on = out_on;
        while (kept < even_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
            else if (pick < 75)
            begin
                b = make_byte(1'b1);
            end
            else if (pick < 90)
            begin
                b = make_byte(1'b0);
            end
            else
            begin
                b = byte_t'($urandom_range(0, 255));
            end
            if (!(^b))
            begin
                kept++;
            end
            send_byte(b);
        end
    endtask

    // Ends the stream on a partial group, which must never come out.
    task automatic test_partial_tail();
        int need;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        // Close any open group first so exactly three bytes stay held.
        need = (held_count == 0) ? 0 : (GROUP_BYTES - held_count);
        repeat (need) send_byte(make_byte(1'b1));
        send_byte(8'h12);
        send_byte(8'h24);
        send_byte(8'h5A);
    endtask

    // Output side: random stalls, and a check of every output transaction.
    initial
    begin : receive_and_check
        int           w;
        bit           got;
        byte_t        seen_byte;
        logic         seen_last;
        packed_byte_t want;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = draw_wait(out_idle_on);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got       = out_valid;
                seen_byte = out_byte;
                seen_last = last_of_group;
                @(posedge clk);
            end
            while (!got);
            bytes_checked++;
            if (pending_bytes.size() == 0)
            begin
                report_failure($sformatf("unexpected output byte %02h last %0b",
                                         seen_byte, seen_last));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (seen_byte !== want.value)
                begin
                    report_failure($sformatf("out_byte expected %02h actual %02h",
                                             want.value, seen_byte));
                end
                if (seen_last !== want.last)
                begin
                    report_failure($sformatf("last_of_group expected %0b actual %0b",
                                             want.last, seen_last));
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        in_valid      <= 1'b0;
        in_byte       <= '0;
        rst_n         <= 1'b0;
        held_bits     = '0;
        held_count    = '0;
        in_idle_on    = 1'b1;
        out_idle_on   = 1'b1;
        items_sent    = 0;
        items_dropped = 0;
        groups_done   = 0;
        bytes_checked = 0;
        failures      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_parity_and_extremes();
        test_all_ones_group();
        test_random_stream(70, 1'b1, 1'b1);
        test_random_stream(70, 1'b0, 1'b0);
        test_random_stream(70, 1'b1, 1'b0);
        test_random_stream(70, 1'b0, 1'b1);
        test_partial_tail();
        in_valid <= 1'b0;

        // Drain the remaining output bytes, then give the block time to misbehave.
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes (%0d odd parity dropped); %0d groups packed, %0d bytes checked.",
                 items_sent, items_dropped, groups_done, bytes_checked);
        $display("%0d errors; %0d data bytes left held in the final partial group.",
                 failures, held_count);
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
